// ===== rtl/core/dtt_pkg.sv =====
package dtt_pkg;

	localparam int TIME_W  = 48;
	localparam int PER_W   = 32;
	localparam int SLOT_W  = 6;
	localparam int MAX_RES = 16;

	localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};
	localparam logic [PER_W-1:0]  WINDOW_RESET = PER_W'(60 * 60 * 1000);

	localparam logic [2:0] CMD_ADD     = 3'd0;
	localparam logic [2:0] CMD_CANCEL  = 3'd1;
	localparam logic [2:0] CMD_REFRESH = 3'd2;
	localparam logic [2:0] CMD_RESET   = 3'd3;
	localparam logic [2:0] CMD_WAIT    = 3'd4;
	localparam logic [2:0] CMD_EXPIRE  = 3'd5;

	typedef struct packed {
		logic              clear;
		logic              seed;
		logic [SLOT_W-1:0] seed_id;
		logic [TIME_W-1:0] seed_dl;
		logic              cand_v;
		logic [SLOT_W-1:0] cand_id;
		logic [TIME_W-1:0] cand_dl;
		logic [PER_W-1:0]  cand_per;
		logic              cand_rec;
		logic              due_only;
		logic              rollover;
		logic [TIME_W-1:0] now;
	} scan_ctl_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] id;
		logic [TIME_W-1:0] dl;
		logic [PER_W-1:0]  per;
		logic              rec;
	} scan_best_t;

endpackage

// ===== rtl/core/deadline_timer_table.sv =====
// add, reset: read, check, update, scan; cancel: read, check; refresh: read, check, update
// next wait: a scan of every slot; expire: setup, then a scan pass per due timer plus a last
// empty pass unless the list fills, then a word per cycle; a stalled output holds the block
// throughput: one item at a time; every scan runs the single deadline comparator once per slot
// reset: all slots free, previous time and front notice cleared, rollover window 3600000 ms
module deadline_timer_table #(
	parameter int TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // timer_id, period_ms, recurring, restart, now_ms
	input  logic [2:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // ok, slot_out, wait_ms, front_inserted, expired, any_active
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dtt_pkg::*;

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int CW = $clog2(TIMERS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_CHK, S_UPD, S_SCAN, S_FRONT, S_WAIT, S_EXP_INIT, S_EXP_PICK, S_EMIT
	} state_t;

	typedef enum logic [1:0] {MODE_FRONT, MODE_WAIT, MODE_EXP} mode_t;

	state_t state_q;
	mode_t  mode_q;

	logic [2:0]        cmd_q;
	logic [3:0]        id_q;
	logic [PER_W-1:0]  per_q;
	logic              rec_q;
	logic              fn_q;
	logic [TIME_W-1:0] now_q;

	logic [TIMERS-1:0] valid_q;
	logic [TIMERS-1:0] taken_q;
	logic [TIME_W-1:0] prev_q;
	logic              front_notified_q;
	logic [PER_W-1:0]  window_q;
	logic              rollover_q;

	logic [TIME_W-1:0] dl_mem  [TIMERS];
	logic [PER_W-1:0]  per_mem [TIMERS];
	logic              rec_mem [TIMERS];
	logic [TIME_W-1:0] rd_dl_s1;
	logic [PER_W-1:0]  rd_per_s1;
	logic              rd_rec_s1;
	logic              cand_v_s1;
	logic [IW-1:0]     idx_s1;

	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     upd_q;
	logic [TIME_W-1:0] start_q;
	logic [PER_W-1:0]  add_q;
	logic [IW-1:0]     list_q [MAX_RES];
	logic [4:0]        n_q;
	logic [3:0]        k_q;

	logic              e_ok_q;
	logic [3:0]        e_slot_q;
	logic [TIME_W-1:0] e_wait_q;
	logic              e_front_q;

	logic              m_tvalid_q;
	logic [55:0]       m_tdata_q;
	logic              m_tlast_q;

	logic [IW-1:0]     raddr;
	logic [IW-1:0]     scan_idx;
	logic [IW-1:0]     id_idx;
	logic              id_in_range;
	logic              id_ok;
	logic              any_active;
	logic              free_found;
	logic [IW-1:0]     free_idx;
	logic              dl_we;
	logic [IW-1:0]     waddr;
	logic [TIME_W-1:0] sum_a;
	logic [PER_W-1:0]  sum_b;
	logic [TIME_W:0]   sum_w;
	logic [TIME_W-1:0] sat_sum;
	logic              out_free;
	logic              emit_list;
	logic              emit_last;
	logic [IW-1:0]     emit_id;

	scan_ctl_t  ctl;
	scan_best_t best;

	assign scan_idx    = cnt_q[IW-1:0];
	assign id_idx      = IW'(id_q);
	assign id_in_range = {28'd0, id_q} < 32'(TIMERS);
	assign id_ok       = id_in_range && valid_q[id_idx];
	assign any_active  = |valid_q;
	assign raddr       = (state_q == S_SCAN) ? scan_idx : id_idx;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// shared saturating adder
	assign sum_a   = (state_q == S_UPD) ? start_q : now_q;
	assign sum_b   = (state_q == S_UPD) ? add_q : best.per;
	assign sum_w   = {1'b0, sum_a} + {17'd0, sum_b};
	assign sat_sum = sum_w[TIME_W] ? TIME_MAX : sum_w[TIME_W-1:0];

	assign dl_we = (state_q == S_UPD) ||
		(state_q == S_EXP_PICK && best.found && best.rec);
	assign waddr = (state_q == S_UPD) ? upd_q : best.id[IW-1:0];

	always_ff @(posedge clk) begin
		if (dl_we) begin
			dl_mem[waddr] <= sat_sum;
		end
		if (state_q == S_UPD && (cmd_q == CMD_ADD || cmd_q == CMD_RESET)) begin
			per_mem[waddr] <= per_q;
		end
		if (state_q == S_UPD && cmd_q == CMD_ADD) begin
			rec_mem[waddr] <= rec_q;
		end
		rd_dl_s1  <= dl_mem[raddr];
		rd_per_s1 <= per_mem[raddr];
		rd_rec_s1 <= rec_mem[raddr];
		idx_s1    <= scan_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_v_s1 <= 1'b0;
		end else begin
			cand_v_s1 <= (state_q == S_SCAN) && ({1'b0, cnt_q} < (CW + 1)'(TIMERS)) &&
				valid_q[scan_idx] && !taken_q[scan_idx] &&
				!(mode_q == MODE_FRONT && scan_idx == upd_q);
		end
	end

	always_comb begin
		ctl          = '0;
		ctl.clear    = (state_q != S_SCAN);
		ctl.seed     = (state_q == S_UPD);
		ctl.seed_id  = SLOT_W'(upd_q);
		ctl.seed_dl  = sat_sum;
		ctl.cand_v   = cand_v_s1;
		ctl.cand_id  = SLOT_W'(idx_s1);
		ctl.cand_dl  = rd_dl_s1;
		ctl.cand_per = rd_per_s1;
		ctl.cand_rec = rd_rec_s1;
		ctl.due_only = (mode_q == MODE_EXP);
		ctl.rollover = rollover_q;
		ctl.now      = now_q;
	end

	dtt_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.best   (best)
	);

	assign out_free  = !m_tvalid_q || m_tready;
	assign emit_list = (cmd_q == CMD_EXPIRE) && (n_q != 5'd0);
	assign emit_last = ({1'b0, k_q} == n_q - 5'd1);
	assign emit_id   = list_q[k_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			mode_q           <= MODE_WAIT;
			valid_q          <= '0;
			taken_q          <= '0;
			prev_q           <= '0;
			front_notified_q <= 1'b0;
			window_q         <= WINDOW_RESET;
			rollover_q       <= 1'b0;
			cnt_q            <= '0;
			n_q              <= '0;
			k_q              <= '0;
			m_tvalid_q       <= 1'b0;
		end else begin
			if (psel && penable && pwrite && !paddr[2]) begin
				window_q <= pwdata;
			end
			if (m_tvalid_q && m_tready && state_q != S_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q     <= s_tuser;
						id_q      <= s_tdata[3:0];
						per_q     <= s_tdata[35:4];
						rec_q     <= s_tdata[36];
						fn_q      <= s_tdata[37];
						now_q     <= s_tdata[85:38];
						e_ok_q    <= 1'b0;
						e_slot_q  <= '0;
						e_wait_q  <= '0;
						e_front_q <= 1'b0;
						n_q       <= '0;
						k_q       <= '0;
						taken_q   <= '0;
						case (s_tuser)
							CMD_ADD, CMD_CANCEL, CMD_REFRESH, CMD_RESET: begin
								state_q <= S_READ;
							end
							CMD_WAIT: begin
								front_notified_q <= 1'b0;
								mode_q           <= MODE_WAIT;
								state_q          <= S_SCAN;
							end
							CMD_EXPIRE: begin
								state_q <= S_EXP_INIT;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					case (cmd_q)
						CMD_ADD: begin
							if (free_found) begin
								upd_q   <= free_idx;
								start_q <= now_q;
								add_q   <= per_q;
								state_q <= S_UPD;
							end else begin
								state_q <= S_EMIT;
							end
						end
						CMD_CANCEL: begin
							if (id_ok) begin
								valid_q[id_idx] <= 1'b0;
								e_ok_q          <= 1'b1;
							end
							state_q <= S_EMIT;
						end
						CMD_REFRESH: begin
							if (id_ok) begin
								upd_q   <= id_idx;
								start_q <= now_q;
								add_q   <= rd_per_s1;
								state_q <= S_UPD;
							end else begin
								state_q <= S_EMIT;
							end
						end
						CMD_RESET: begin
							if (id_in_range && !fn_q && rd_per_s1 == per_q) begin
								e_ok_q  <= 1'b1;
								state_q <= S_EMIT;
							end else if (id_ok) begin
								upd_q <= id_idx;
								add_q <= per_q;
								if (fn_q) begin
									start_q <= now_q;
								end else if (rd_dl_s1 >= {16'd0, rd_per_s1}) begin
									start_q <= rd_dl_s1 - {16'd0, rd_per_s1};
								end else begin
									start_q <= '0;
								end
								state_q <= S_UPD;
							end else begin
								state_q <= S_EMIT;
							end
						end
						default: begin
							e_ok_q  <= 1'b0;
							state_q <= S_EMIT;
						end
					endcase
				end
				S_UPD: begin
					e_ok_q <= 1'b1;
					if (cmd_q == CMD_ADD) begin
						valid_q[upd_q] <= 1'b1;
					end
					if (cmd_q == CMD_REFRESH) begin
						state_q <= S_EMIT;
					end else begin
						mode_q  <= MODE_FRONT;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == CW'(TIMERS)) begin
						cnt_q <= '0;
						case (mode_q)
							MODE_FRONT: state_q <= S_FRONT;
							MODE_WAIT:  state_q <= S_WAIT;
							default:    state_q <= S_EXP_PICK;
						endcase
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FRONT: begin
					if (best.id == SLOT_W'(upd_q) && !front_notified_q) begin
						e_front_q        <= 1'b1;
						front_notified_q <= 1'b1;
					end
					if (cmd_q == CMD_ADD) begin
						e_slot_q <= 4'(upd_q);
					end
					state_q <= S_EMIT;
				end
				S_WAIT: begin
					e_ok_q <= 1'b1;
					if (!best.found) begin
						e_wait_q <= TIME_MAX;
					end else if (now_q >= best.dl) begin
						e_wait_q <= '0;
					end else begin
						e_wait_q <= best.dl - now_q;
					end
					state_q <= S_EMIT;
				end
				S_EXP_INIT: begin
					taken_q    <= '0;
					rollover_q <= any_active && (prev_q > {16'd0, window_q}) &&
						(now_q < prev_q - {16'd0, window_q});
					if (any_active) begin
						prev_q <= now_q;
					end
					mode_q  <= MODE_EXP;
					state_q <= S_SCAN;
				end
				S_EXP_PICK: begin
					e_ok_q <= 1'b1;
					if (best.found) begin
						list_q[n_q[3:0]]         <= best.id[IW-1:0];
						taken_q[best.id[IW-1:0]] <= 1'b1;
						if (!best.rec) begin
							valid_q[best.id[IW-1:0]] <= 1'b0;
						end
						n_q <= n_q + 5'd1;
						if (n_q != 5'(MAX_RES - 1)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (emit_list) begin
							m_tdata_q <= {any_active, 1'b1, 1'b0, {TIME_W{1'b0}},
								4'(emit_id), 1'b1};
							m_tlast_q <= emit_last;
							k_q       <= k_q + 4'd1;
							if (emit_last) begin
								state_q <= S_IDLE;
							end
						end else begin
							m_tdata_q <= {any_active, 1'b0, e_front_q, e_wait_q, e_slot_q, e_ok_q};
							m_tlast_q <= 1'b1;
							state_q   <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'd0 : window_q;

`ifndef SYNTHESIS
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !dl_we)
		else $error("table written during scan");

	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 5'(MAX_RES))
		else $error("expire list overflow");

	a_front_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRONT) |-> best.found)
		else $error("front scan lost its seed");

	a_listed_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && emit_list) |-> taken_q[emit_id])
		else $error("expired word names a slot not taken");
`endif

endmodule

// ===== rtl/core/dtt_scan.sv =====
module dtt_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  dtt_pkg::scan_ctl_t  ctl,
	output dtt_pkg::scan_best_t best
);
	import dtt_pkg::*;

	scan_best_t best_q;
	logic       eligible;
	logic       better;

	assign eligible = ctl.cand_v && (!ctl.due_only || ctl.rollover || ctl.cand_dl <= ctl.now);
	assign better   = !best_q.found || ctl.cand_dl < best_q.dl ||
		(ctl.cand_dl == best_q.dl && ctl.cand_id < best_q.id);

	// earliest deadline, ties to the lower slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q.found <= 1'b0;
		end else if (ctl.clear) begin
			best_q.found <= ctl.seed;
			best_q.id    <= ctl.seed_id;
			best_q.dl    <= ctl.seed_dl;
		end else if (eligible && better) begin
			best_q.found <= 1'b1;
			best_q.id    <= ctl.cand_id;
			best_q.dl    <= ctl.cand_dl;
			best_q.per   <= ctl.cand_per;
			best_q.rec   <= ctl.cand_rec;
		end
	end

	assign best = best_q;

endmodule

// ===== tb/tb_deadline_timer_table.sv =====
`default_nettype none

module tb_deadline_timer_table;
	timeunit 1ns;
	timeprecision 1ps;
	import dtt_pkg::*;

	localparam int SLOTS = 16;
	localparam int WATCH_LIMIT = 4000;
	localparam int SETTLE = 400;
	localparam logic [2:0] CMD_BAD6 = 3'd6;
	localparam logic [2:0] CMD_BAD7 = 3'd7;
	localparam logic [2:0] ADDR_WINDOW = 3'd0;

	typedef struct {
		bit ok;
		bit [3:0] slot;
		bit [47:0] wait_ms;
		bit front;
		bit exp;
		bit any;
		bit last;
	} timer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [87:0] s_tdata = '0;  // timer_id, period_ms, recurring, restart, now_ms
	logic [2:0] s_tuser = '0;   // command
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;       // ok, slot_out, wait_ms, front_inserted, expired, any_active
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	deadline_timer_table dut (.*);

	always #4 clk = ~clk;

	// timer table copy
	bit tt_valid[SLOTS];
	bit tt_rec[SLOTS];
	bit [31:0] tt_period[SLOTS];
	bit [47:0] tt_deadline[SLOTS];
	bit tt_written[SLOTS];
	bit [47:0] tt_prev;
	bit tt_notified;
	bit [31:0] tt_window = WINDOW_RESET;

	timer_result_t expected_words[$];
	int errors = 0;
	bit hold_req = 0;
	bit [47:0] clock_ms = 0;

	function automatic bit [47:0] sat_add(bit [47:0] a, bit [31:0] b);
		bit [48:0] s = {1'b0, a} + b;
		return s[48] ? TIME_MAX : s[47:0];
	endfunction

	function automatic bit earlier(int a, int b);
		if (tt_deadline[a] != tt_deadline[b])
			return tt_deadline[a] < tt_deadline[b];
		return a < b;
	endfunction

	function automatic bit any_timer();
		foreach (tt_valid[i])
			if (tt_valid[i])
				return 1;
		return 0;
	endfunction

	function automatic bit front_check(int s);
		for (int j = 0; j < SLOTS; j++)
			if (j != s && tt_valid[j] && !earlier(s, j))
				return 0;
		if (tt_notified)
			return 0;
		tt_notified = 1;
		return 1;
	endfunction

	function automatic void push_word(bit ok, bit [3:0] slot, bit [47:0] w, bit front,
			bit exp, bit last);
		timer_result_t r;
		r.ok = ok; r.slot = slot; r.wait_ms = w; r.front = front;
		r.exp = exp; r.any = any_timer(); r.last = last;
		expected_words.insert(expected_words.size(), r);
	endfunction

	function automatic void predict_word(bit [2:0] cmd, bit [3:0] id, bit [31:0] per,
			bit rec, bit fn, bit [47:0] now);
		int slot;
		int best;
		bit found;
		bit roll;
		bit taken[SLOTS];
		int due[$];
		bit [47:0] start;
		case (cmd)
		CMD_ADD: begin
			slot = -1;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!tt_valid[i])
					slot = i;
			if (slot < 0) begin
				push_word(0, 0, 0, 0, 0, 1);
			end else begin
				tt_valid[slot] = 1; tt_rec[slot] = rec; tt_period[slot] = per;
				tt_written[slot] = 1;
				tt_deadline[slot] = sat_add(now, per);
				push_word(1, slot[3:0], 0, front_check(slot), 0, 1);
			end
		end
		CMD_CANCEL, CMD_REFRESH: begin
			if (!tt_valid[id]) begin
				push_word(0, 0, 0, 0, 0, 1);
			end else begin
				if (cmd == CMD_CANCEL)
					tt_valid[id] = 0;
				else
					tt_deadline[id] = sat_add(now, tt_period[id]);
				push_word(1, 0, 0, 0, 0, 1);
			end
		end
		CMD_RESET: begin
			if (!fn && tt_period[id] == per) begin
				push_word(1, 0, 0, 0, 0, 1);
			end else if (!tt_valid[id]) begin
				push_word(0, 0, 0, 0, 0, 1);
			end else begin
				if (fn)
					start = now;
				else if (tt_deadline[id] >= tt_period[id])
					start = tt_deadline[id] - tt_period[id];
				else
					start = 0;
				tt_period[id] = per;
				tt_deadline[id] = sat_add(start, per);
				push_word(1, 0, 0, front_check(id), 0, 1);
			end
		end
		CMD_WAIT: begin
			tt_notified = 0;
			found = 0; best = 0;
			for (int i = 0; i < SLOTS; i++)
				if (tt_valid[i] && (!found || earlier(i, best))) begin
					best = i; found = 1;
				end
			if (!found)
				push_word(1, 0, TIME_MAX, 0, 0, 1);
			else
				push_word(1, 0, now >= tt_deadline[best] ? 48'd0 : tt_deadline[best] - now,
					0, 0, 1);
		end
		CMD_EXPIRE: begin
			roll = 0;
			if (any_timer()) begin
				roll = tt_prev > tt_window && now < tt_prev - tt_window;
				tt_prev = now;
			end
			while (due.size() < MAX_RES) begin
				found = 0; best = 0;
				for (int i = 0; i < SLOTS; i++) begin
					if (!tt_valid[i] || taken[i] || (!roll && tt_deadline[i] > now))
						continue;
					if (!found || earlier(i, best)) begin
						best = i; found = 1;
					end
				end
				if (!found)
					break;
				taken[best] = 1;
				due.insert(due.size(), best);
			end
			foreach (due[k])
				if (tt_rec[due[k]])
					tt_deadline[due[k]] = sat_add(now, tt_period[due[k]]);
				else
					tt_valid[due[k]] = 0;
			if (due.size() == 0)
				push_word(1, 0, 0, 0, 0, 1);
			foreach (due[k])
				push_word(1, due[k][3:0], 0, 0, 1, k == due.size() - 1);
		end
		default: begin
			push_word(0, 0, 0, 0, 0, 1);
		end
		endcase
	endfunction

	task automatic send_word(bit [2:0] cmd, bit [3:0] id = 0, bit [31:0] per = 0,
			bit rec = 0, bit fn = 0, bit [47:0] now = clock_ms);
		int gap = $urandom_range(0, 6);
		if (cmd == CMD_RESET && !fn && !tt_written[id])
			fn = 1;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, now, fn, rec, per, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_word(cmd, id, per, rec, fn, now);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_window(bit [31:0] v);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_WINDOW; pwdata <= v; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tt_window = v;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// ready side with random stalls and one long hold
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		timer_result_t e;
		if (m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word %h", m_tdata);
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (m_tdata[0] !== e.ok) begin
					$error("ok exp %0d got %0d", e.ok, m_tdata[0]); errors++;
				end
				if (m_tdata[4:1] !== e.slot) begin
					$error("slot_out exp %0d got %0d", e.slot, m_tdata[4:1]); errors++;
				end
				if (m_tdata[52:5] !== e.wait_ms) begin
					$error("wait_ms exp %0d got %0d", e.wait_ms, m_tdata[52:5]); errors++;
				end
				if (m_tdata[53] !== e.front) begin
					$error("front_inserted exp %0d got %0d", e.front, m_tdata[53]); errors++;
				end
				if (m_tdata[54] !== e.exp) begin
					$error("expired exp %0d got %0d", e.exp, m_tdata[54]); errors++;
				end
				if (m_tdata[55] !== e.any) begin
					$error("any_active exp %0d got %0d", e.any, m_tdata[55]); errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last exp %0d got %0d", e.last, m_tlast); errors++;
				end
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (expected_words.size() == 0 && !s_tvalid))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_basics();
		send_word(CMD_WAIT, .now(0));
		send_word(CMD_EXPIRE, .now(0));
		send_word(CMD_ADD, .per(0), .rec(1), .now(100));
		send_word(CMD_ADD, .per(32'hFFFF_FFFF), .now(48'hFFFF_FFFF_FFF0));
		send_word(CMD_ADD, .per(50), .now(20));
		send_word(CMD_WAIT, .now(30));
		send_word(CMD_WAIT, .now(200));
		send_word(CMD_ADD, .per(5), .now(20));
		send_word(CMD_RESET, .id(2), .per(50), .fn(0), .now(40));
		send_word(CMD_RESET, .id(2), .per(10), .fn(0), .now(40));
		send_word(CMD_RESET, .id(3), .per(400), .fn(1), .now(45));
		send_word(CMD_REFRESH, .id(1), .now(60));
		send_word(CMD_CANCEL, .id(9), .now(60));
		send_word(CMD_REFRESH, .id(9), .now(60));
		send_word(CMD_RESET, .id(9), .per(7), .fn(1), .now(60));
		send_word(CMD_CANCEL, .id(3), .now(60));
		send_word(CMD_BAD6, .id(15), .per(32'hFFFF_FFFF), .rec(1), .fn(1), .now(TIME_MAX));
		send_word(CMD_BAD7);
		send_word(CMD_EXPIRE, .now(500));
		drain();
	endtask

	task automatic test_full_table();
		for (int i = 0; i < SLOTS + 1; i++)
			send_word(CMD_ADD, .per($urandom_range(0, 3)), .rec(i[0]), .now(1000));
		send_word(CMD_EXPIRE, .now(1010));
		send_word(CMD_WAIT, .now(1010));
		drain();
	endtask

	task automatic test_rollover();
		write_window(100);
		for (int i = 0; i < 4; i++)
			send_word(CMD_ADD, .per(1_000_000), .rec(i[0]), .now(10000));
		send_word(CMD_EXPIRE, .now(10000));
		send_word(CMD_EXPIRE, .now(9950));
		send_word(CMD_EXPIRE, .now(500));
		drain();
		write_window(0);
		send_word(CMD_EXPIRE, .now(400));
		send_word(CMD_EXPIRE, .now(399));
		drain();
		write_window(32'hFFFF_FFFF);
		send_word(CMD_EXPIRE, .now(0));
		drain();
	endtask

	task automatic random_words(int count);
		bit [2:0] cmd;
		bit [31:0] per;
		bit [47:0] now;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 19))
			0: clock_ms = 48'({$urandom, $urandom});
			1: clock_ms = clock_ms > 5000 ? clock_ms - $urandom_range(0, 5000) : 48'd0;
			default: clock_ms = clock_ms + $urandom_range(0, 60);
			endcase
			now = clock_ms;
			case ($urandom_range(0, 15))
			0, 1, 2, 3: cmd = CMD_ADD;
			4: cmd = CMD_CANCEL;
			5, 6: cmd = CMD_REFRESH;
			7, 8: cmd = CMD_RESET;
			9, 10: cmd = CMD_WAIT;
			11, 12, 13: cmd = CMD_EXPIRE;
			14: cmd = 3'($urandom_range(0, 7));
			default: cmd = CMD_EXPIRE;
			endcase
			per = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 120);
			send_word(cmd, 4'($urandom_range(0, 15)), per, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), now);
		end
	endtask

	task automatic test_random();
		write_window(2000);
		clock_ms = 20000;
		random_words(100);
		drain();
		write_window($urandom_range(0, 300));
		random_words(100);
		drain();
		write_window(WINDOW_RESET);
		random_words(60);
		drain();
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		random_words(30);
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basics();
		test_full_table();
		test_rollover();
		test_random();
		test_backpressure();
		if (errors == 0 && expected_words.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
